@@ rtl/momentary_loudness_meter_macros.svh @@
// Assertion macros used by the loudness meter back end.
`ifndef MOMENTARY_LOUDNESS_METER_MACROS_SVH
`define MOMENTARY_LOUDNESS_METER_MACROS_SVH

// Same-cycle implication under asynchronous reset.
`define MLM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("momentary loudness meter: same-cycle check failed");

// Next-cycle implication under asynchronous reset.
`define MLM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("momentary loudness meter: next-cycle check failed");

`endif

@@ rtl/mlm_pkg.sv @@
package mlm_pkg;

	localparam int WINDOW_DEPTH_DEF = 32768;
	localparam int SAMPLE_BITS_DEF  = 24;
	localparam int QUEUE_DEPTH      = 4;

	localparam logic [15:0] WINDOW_LENGTH_RST  = 16'd19200;
	localparam logic [15:0] CHANNEL_GAIN_RST   = 16'd16384;
	localparam logic [15:0] LOUDNESS_FLOOR_RST = 16'hBA00;

	localparam logic [17:0] DB_PER_OCTAVE_Q16 = 18'd197284;
	localparam logic signed [47:0] OFFSET_Q32 = -48'sd2967822402;
	localparam logic signed [22:0] LOG2_BIAS  = 23'sd2752512;

	typedef enum logic [1:0] {
		REG_WINDOW_LENGTH  = 2'd0,
		REG_CHANNEL_GAIN   = 2'd1,
		REG_LOUDNESS_FLOOR = 2'd2,
		REG_MONO_MODE      = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [15:0]        window_length;
		logic [15:0]        channel_gain;
		logic signed [15:0] loudness_floor;
		logic               mono_mode;
	} cfg_t;

	typedef struct packed {
		logic [31:0] sq_l;
		logic [31:0] sq_r;
		logic        block_end;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef enum logic [2:0] {
		F_IDLE, F_MAC, F_WB, F_SQ, F_SQW, F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE, B_RD, B_UPD, B_CHK, B_DIV, B_MUL, B_NORM,
		B_SQR, B_ADJ, B_LOGM, B_FIN, B_OUT
	} back_state_t;

	// K-weighting coefficients in Q.30: b0, b1, b2, -a1, -a2.
	function automatic logic signed [33:0] kw_coef(input logic filt, input logic [2:0] term);
		logic signed [33:0] c;
		c = '0;
		if (!filt) begin
			case (term)
				3'd0: c = 34'sd1648327767;
				3'd1: c = -34'sd2890186776;
				3'd2: c = 34'sd1286764483;
				3'd3: c = 34'sd1815331593;
				default: c = -34'sd786495243;
			endcase
		end else begin
			case (term)
				3'd0: c = 34'sd1073741824;
				3'd1: c = -34'sd2147483648;
				3'd2: c = 34'sd1073741824;
				3'd3: c = 34'sd2136797184;
				default: c = -34'sd1063081984;
			endcase
		end
		return c;
	endfunction

endpackage

@@ rtl/mlm_queue.sv @@
module mlm_queue #(
	parameter int DEPTH = mlm_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mlm_pkg::q_entry_t  push_data,
	input  logic               pop,
	output mlm_pkg::q_entry_t  head,
	output mlm_pkg::q_stat_t   stat
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	mlm_pkg::q_entry_t mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   cnt_q;

	assign head       = mem_q[rptr_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == (AW+1)'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			if (pop)  rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

endmodule

@@ rtl/mlm_front.sv @@
module mlm_front #(
	parameter int SAMPLE_BITS = mlm_pkg::SAMPLE_BITS_DEF,
	parameter int IN_W        = ((2*SAMPLE_BITS+7)/8)*8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [IN_W-1:0]    s_axis_tdata,
	input  logic               s_axis_tlast,
	input  logic               mono_mode,
	output logic               push,
	output mlm_pkg::q_entry_t  push_data,
	input  mlm_pkg::q_stat_t   qstat
);
	localparam int SH_L = (SAMPLE_BITS <= 29) ? 29 - SAMPLE_BITS : 0;
	localparam int SH_R = (SAMPLE_BITS > 29) ? SAMPLE_BITS - 29 : 0;

	function automatic logic signed [31:0] to_q28(input logic signed [SAMPLE_BITS-1:0] s);
		logic signed [63:0] e;
		e = (64'(s) <<< SH_L) >>> SH_R;
		return e[31:0];
	endfunction

	mlm_pkg::front_state_t state_q, state_d;

	logic signed [31:0] grp_q [4][4];
	logic signed [31:0] x_q, xr_q;
	logic               be_q, ch_q, filt_q;
	logic [2:0]         term_q;
	logic signed [39:0] acc_q;
	logic signed [65:0] prod_q;
	logic [31:0]        sql_q, sqr_q;

	logic signed [33:0] op_c;
	logic signed [31:0] op_d;
	logic signed [65:0] mult;
	logic signed [39:0] term_val, sum;
	logic signed [31:0] y;
	logic [31:0]        sq;

	always_comb begin
		op_c = mlm_pkg::kw_coef(filt_q, term_q);
		case (term_q)
			3'd0: op_d = x_q;
			3'd1: op_d = grp_q[0][0];
			3'd2: op_d = grp_q[0][1];
			3'd3: op_d = grp_q[0][2];
			default: op_d = grp_q[0][3];
		endcase
		if (state_q == mlm_pkg::F_SQ) begin
			op_c = 34'(x_q);
			op_d = x_q;
		end
		mult     = 66'(op_c) * 66'(op_d);
		term_val = 40'($signed(prod_q[65:30]));
		sum      = acc_q + term_val;
		if (sum > 40'sd2147483647) y = 32'sh7FFFFFFF;
		else if (sum < -40'sd2147483648) y = 32'sh80000000;
		else y = sum[31:0];
		sq = (prod_q[65:60] != '0) ? 32'hFFFFFFFF : prod_q[59:28];
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		push          = 1'b0;
		case (state_q)
			mlm_pkg::F_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_d = mlm_pkg::F_MAC;
			end
			mlm_pkg::F_MAC: if (term_q == 3'd4) state_d = mlm_pkg::F_WB;
			mlm_pkg::F_WB: state_d = filt_q ? mlm_pkg::F_SQ : mlm_pkg::F_MAC;
			mlm_pkg::F_SQ: state_d = mlm_pkg::F_SQW;
			mlm_pkg::F_SQW: state_d = ch_q ? mlm_pkg::F_PUSH : mlm_pkg::F_MAC;
			mlm_pkg::F_PUSH: begin
				if (!qstat.full) begin
					push    = 1'b1;
					state_d = mlm_pkg::F_IDLE;
				end
			end
			default: state_d = mlm_pkg::F_IDLE;
		endcase
	end

	assign push_data.sq_l      = sql_q;
	assign push_data.sq_r      = sqr_q;
	assign push_data.block_end = be_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mlm_pkg::F_IDLE;
		else state_q <= state_d;
	end

	// Filter state rotates as a ring so the active biquad always sits in group zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					grp_q[i][j] <= '0;
		end else if (state_q == mlm_pkg::F_WB) begin
			for (int i = 0; i < 3; i++) grp_q[i] <= grp_q[i+1];
			grp_q[3][0] <= x_q;
			grp_q[3][1] <= grp_q[0][0];
			grp_q[3][2] <= y;
			grp_q[3][3] <= grp_q[0][2];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mlm_pkg::F_IDLE: begin
				x_q    <= to_q28(s_axis_tdata[SAMPLE_BITS-1:0]);
				xr_q   <= mono_mode ? '0 : to_q28(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
				be_q   <= s_axis_tlast;
				ch_q   <= 1'b0;
				filt_q <= 1'b0;
				term_q <= '0;
			end
			mlm_pkg::F_MAC: begin
				prod_q <= mult;
				acc_q  <= (term_q == 3'd0) ? '0 : sum;
				term_q <= term_q + 3'd1;
			end
			mlm_pkg::F_WB: begin
				x_q    <= y;
				filt_q <= 1'b1;
				term_q <= '0;
			end
			mlm_pkg::F_SQ: prod_q <= mult;
			mlm_pkg::F_SQW: begin
				if (!ch_q) sql_q <= sq;
				else sqr_q <= sq;
				ch_q   <= 1'b1;
				filt_q <= 1'b0;
				x_q    <= xr_q;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/mlm_back.sv @@
`include "momentary_loudness_meter_macros.svh"

module mlm_back #(
	parameter int WINDOW_DEPTH = mlm_pkg::WINDOW_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mlm_pkg::cfg_t      cfg,
	input  logic               clr,
	input  mlm_pkg::q_entry_t  head,
	input  mlm_pkg::q_stat_t   qstat,
	output logic               pop,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [15:0]        m_axis_tdata
);
	localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

	mlm_pkg::back_state_t state_q, state_d;

	logic [31:0] mem_l [WINDOW_DEPTH];
	logic [31:0] mem_r [WINDOW_DEPTH];

	mlm_pkg::q_entry_t ent_q;
	logic [15:0]  pos_q;
	logic         filled_q;
	logic [47:0]  suml_q, sumr_q;
	logic [31:0]  rdl_q, rdr_q;
	logic [16:0]  cnt_q, reml_q, remr_q;
	logic [47:0]  dl_q, dr_q;
	logic [5:0]   bit_q, e_q;
	logic [48:0]  w_q;
	logic [31:0]  m_q;
	logic [63:0]  sq_q;
	logic [15:0]  frac_q;
	logic [3:0]   it_q;
	logic signed [47:0] v_q;
	logic [15:0]  loud_q;

	logic [16:0]  len, count;
	logic [AW-1:0] addr;
	logic [17:0]  tl, tr, nl, nr;
	logic         gl, gr;
	logic [32:0]  t_adj, ms_sum;
	logic [31:0]  msr;
	logic signed [22:0] l2d;
	logic signed [47:0] vs;
	logic signed [23:0] r;
	logic signed [15:0] rs;

	always_comb begin
		len    = (17'(cfg.window_length) < 17'(WINDOW_DEPTH)) ? 17'(cfg.window_length)
		                                                      : 17'(WINDOW_DEPTH);
		count  = filled_q ? len : 17'(pos_q);
		addr   = pos_q[AW-1:0];
		tl     = {reml_q, dl_q[47]};
		tr     = {remr_q, dr_q[47]};
		gl     = tl >= {1'b0, cnt_q};
		gr     = tr >= {1'b0, cnt_q};
		nl     = gl ? tl - {1'b0, cnt_q} : tl;
		nr     = gr ? tr - {1'b0, cnt_q} : tr;
		t_adj  = sq_q[63:31];
		msr    = cfg.mono_mode ? dl_q[31:0] : dr_q[31:0];
		ms_sum = 33'(dl_q[31:0]) + 33'(msr);
		l2d    = $signed({1'b0, e_q, frac_q}) - mlm_pkg::LOG2_BIAS;
		vs     = v_q + mlm_pkg::OFFSET_Q32 + 48'sd8388608;
		r      = vs[47:24];
		if (r > 24'sd32767) rs = 16'sh7FFF;
		else if (r < -24'sd32768) rs = 16'sh8000;
		else rs = r[15:0];
		if (rs < cfg.loudness_floor) rs = cfg.loudness_floor;
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			mlm_pkg::B_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_d = (len != '0) ? mlm_pkg::B_RD : mlm_pkg::B_CHK;
				end
			end
			mlm_pkg::B_RD:  state_d = mlm_pkg::B_UPD;
			mlm_pkg::B_UPD: state_d = mlm_pkg::B_CHK;
			mlm_pkg::B_CHK: begin
				if (!ent_q.block_end) state_d = mlm_pkg::B_IDLE;
				else if (count == '0) state_d = mlm_pkg::B_OUT;
				else state_d = mlm_pkg::B_DIV;
			end
			mlm_pkg::B_DIV: if (bit_q == '0) state_d = mlm_pkg::B_MUL;
			mlm_pkg::B_MUL: state_d = mlm_pkg::B_NORM;
			mlm_pkg::B_NORM: begin
				if (w_q == '0) state_d = mlm_pkg::B_OUT;
				else if (w_q[48]) state_d = mlm_pkg::B_SQR;
			end
			mlm_pkg::B_SQR: state_d = mlm_pkg::B_ADJ;
			mlm_pkg::B_ADJ: state_d = (it_q == '0) ? mlm_pkg::B_LOGM : mlm_pkg::B_SQR;
			mlm_pkg::B_LOGM: state_d = mlm_pkg::B_FIN;
			mlm_pkg::B_FIN: state_d = mlm_pkg::B_OUT;
			mlm_pkg::B_OUT: if (m_axis_tready) state_d = mlm_pkg::B_IDLE;
			default: state_d = mlm_pkg::B_IDLE;
		endcase
	end

	assign m_axis_tvalid = (state_q == mlm_pkg::B_OUT);
	assign m_axis_tdata  = loud_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mlm_pkg::B_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			filled_q <= 1'b0;
			suml_q   <= '0;
			sumr_q   <= '0;
		end else if (clr) begin
			pos_q    <= '0;
			filled_q <= 1'b0;
			suml_q   <= '0;
			sumr_q   <= '0;
		end else if (state_q == mlm_pkg::B_UPD) begin
			suml_q <= suml_q - (filled_q ? 48'(rdl_q) : '0) + 48'(ent_q.sq_l);
			sumr_q <= sumr_q - (filled_q ? 48'(rdr_q) : '0) + 48'(ent_q.sq_r);
			if (17'(pos_q) + 17'd1 >= len) begin
				pos_q    <= '0;
				filled_q <= 1'b1;
			end else begin
				pos_q <= pos_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mlm_pkg::B_RD) begin
			rdl_q       <= mem_l[addr];
			rdr_q       <= mem_r[addr];
			mem_l[addr] <= ent_q.sq_l;
			mem_r[addr] <= ent_q.sq_r;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mlm_pkg::B_IDLE: if (pop) ent_q <= head;
			mlm_pkg::B_CHK: begin
				cnt_q  <= count;
				dl_q   <= suml_q;
				dr_q   <= sumr_q;
				reml_q <= '0;
				remr_q <= '0;
				bit_q  <= 6'd47;
				loud_q <= cfg.loudness_floor;
			end
			mlm_pkg::B_DIV: begin
				reml_q <= nl[16:0];
				remr_q <= nr[16:0];
				dl_q   <= {dl_q[46:0], gl};
				dr_q   <= {dr_q[46:0], gr};
				bit_q  <= bit_q - 6'd1;
			end
			mlm_pkg::B_MUL: begin
				w_q <= 49'(cfg.channel_gain) * 49'(ms_sum);
				e_q <= 6'd48;
			end
			mlm_pkg::B_NORM: begin
				if (w_q[48]) begin
					m_q    <= w_q[48:17];
					it_q   <= 4'd15;
					frac_q <= '0;
				end else begin
					w_q <= {w_q[47:0], 1'b0};
					e_q <= e_q - 6'd1;
				end
			end
			mlm_pkg::B_SQR: sq_q <= 64'(m_q) * 64'(m_q);
			mlm_pkg::B_ADJ: begin
				if (t_adj[32]) begin
					m_q          <= t_adj[32:1];
					frac_q[it_q] <= 1'b1;
				end else begin
					m_q <= t_adj[31:0];
				end
				it_q <= it_q - 4'd1;
			end
			mlm_pkg::B_LOGM: v_q <= 48'(l2d) * $signed({30'd0, mlm_pkg::DB_PER_OCTAVE_Q16});
			mlm_pkg::B_FIN: loud_q <= rs;
			default: ;
		endcase
	end

	`MLM_ASSERT_IMP(a_pos_in_window, clk, arst_n, 1'b1, (pos_q == '0) || (17'(pos_q) < len))
	`MLM_ASSERT_IMP(a_filled_nonzero, clk, arst_n, filled_q, len != '0)
	`MLM_ASSERT_IMP(a_mean_fits, clk, arst_n, state_q == mlm_pkg::B_MUL, (dl_q[47:32] == '0) && (dr_q[47:32] == '0))
	`MLM_ASSERT_NXT(a_result_floor, clk, arst_n, state_q == mlm_pkg::B_FIN, $signed(loud_q) >= cfg.loudness_floor)

endmodule

@@ rtl/momentary_loudness_meter.sv @@
// Momentary loudness meter: each stereo frame is K-weighted (two biquads per channel on one
// shared 34x32 multiplier), squared and pushed into a sliding window; a frame with
// tlast set yields one Q8.8 LKFS result, never below loudness_floor. The filter front
// end takes one frame at a time, one multiply per cycle, and stalls while the four-entry
// queue feeding the window back end is full. Per frame the back end replaces the oldest
// square and updates the running sums (skipping both for a zero window length); a block
// end frame adds a bit-serial mean divider, a normalizing shift and 16 squarings for the
// logarithm. The window stores are undefined after reset and need no clearing pass.
module momentary_loudness_meter #(
	parameter int WINDOW_DEPTH = mlm_pkg::WINDOW_DEPTH_DEF,
	parameter int SAMPLE_BITS  = mlm_pkg::SAMPLE_BITS_DEF,
	parameter int IN_W         = ((2*SAMPLE_BITS+7)/8)*8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [IN_W-1:0] s_axis_tdata,   // left_sample, right_sample
	input  logic            s_axis_tlast,   // block_end
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [15:0]     m_axis_tdata,   // loudness
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [3:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	mlm_pkg::cfg_t      cfg_q;
	mlm_pkg::q_entry_t  push_data, head;
	mlm_pkg::q_stat_t   qstat;
	mlm_pkg::reg_index_t idx;
	logic push, pop, wr, clr;

	assign pready = 1'b1;
	assign idx    = mlm_pkg::reg_index_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;
	assign clr    = wr && (idx == mlm_pkg::REG_WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length  <= mlm_pkg::WINDOW_LENGTH_RST;
			cfg_q.channel_gain   <= mlm_pkg::CHANNEL_GAIN_RST;
			cfg_q.loudness_floor <= mlm_pkg::LOUDNESS_FLOOR_RST;
			cfg_q.mono_mode      <= 1'b0;
		end else if (wr) begin
			case (idx)
				mlm_pkg::REG_WINDOW_LENGTH:  cfg_q.window_length  <= pwdata[15:0];
				mlm_pkg::REG_CHANNEL_GAIN:   cfg_q.channel_gain   <= pwdata[15:0];
				mlm_pkg::REG_LOUDNESS_FLOOR: cfg_q.loudness_floor <= pwdata[15:0];
				mlm_pkg::REG_MONO_MODE:      cfg_q.mono_mode      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mlm_pkg::REG_WINDOW_LENGTH:  prdata = {16'd0, cfg_q.window_length};
			mlm_pkg::REG_CHANNEL_GAIN:   prdata = {16'd0, cfg_q.channel_gain};
			mlm_pkg::REG_LOUDNESS_FLOOR: prdata = {16'd0, cfg_q.loudness_floor};
			mlm_pkg::REG_MONO_MODE:      prdata = {31'd0, cfg_q.mono_mode};
			default:                     prdata = '0;
		endcase
	end

	mlm_front #(.SAMPLE_BITS(SAMPLE_BITS), .IN_W(IN_W)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.mono_mode(cfg_q.mono_mode),
		.push(push), .push_data(push_data), .qstat(qstat)
	);

	mlm_queue #(.DEPTH(mlm_pkg::QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data),
		.pop(pop), .head(head), .stat(qstat)
	);

	mlm_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg(cfg_q), .clr(clr),
		.head(head), .qstat(qstat), .pop(pop),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

endmodule

@@ verif/momentary_loudness_meter_checker.sv @@
module momentary_loudness_meter_checker
	import mlm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // left_sample, right_sample
	input  logic        s_axis_tlast,   // block_end
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // loudness
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);

	localparam longint KW [2][5] = '{
		'{64'sd1648327767, -64'sd2890186776, 64'sd1286764483, 64'sd1815331593,
			-64'sd786495243},
		'{64'sd1073741824, -64'sd2147483648, 64'sd1073741824, 64'sd2136797184,
			-64'sd1063081984}
	};

	logic signed [31:0] taps [2][8];
	logic [31:0]        square_store [2][WINDOW_DEPTH_DEF];
	logic [63:0]        power_sum [2];
	int unsigned        wpos;
	bit                 filled;
	cfg_t               cfg;
	logic signed [15:0] loudness_due [$];
	int                 mismatches;

	function automatic logic signed [31:0] to_q28(input logic [23:0] s);
		return {{8{s[23]}}, s} << 5;
	endfunction

	function automatic logic signed [31:0] biquad_step(input int ch, input int sec,
			input logic signed [31:0] x0);
		longint acc;
		logic signed [31:0] y;
		int b;
		b = sec * 4;
		acc = ((KW[sec][0] * longint'(x0)) >>> 30)
			+ ((KW[sec][1] * longint'(taps[ch][b])) >>> 30)
			+ ((KW[sec][2] * longint'(taps[ch][b+1])) >>> 30)
			+ ((KW[sec][3] * longint'(taps[ch][b+2])) >>> 30)
			+ ((KW[sec][4] * longint'(taps[ch][b+3])) >>> 30);
		if (acc > 64'sd2147483647) begin
			y = 32'sh7FFFFFFF;
		end else if (acc < -64'sd2147483648) begin
			y = 32'sh80000000;
		end else begin
			y = acc[31:0];
		end
		taps[ch][b+1] = taps[ch][b];
		taps[ch][b] = x0;
		taps[ch][b+3] = taps[ch][b+2];
		taps[ch][b+2] = y;
		return y;
	endfunction

	function automatic logic [31:0] square_q28(input logic signed [31:0] w);
		logic [63:0] a;
		logic [63:0] sq;
		a = (w < 0) ? 64'(-longint'(w)) : 64'(longint'(w));
		sq = (a * a) >> 28;
		return (sq > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sq[31:0];
	endfunction

	function automatic logic signed [15:0] loudness_from_power(input logic [63:0] w);
		int e;
		logic [63:0] m;
		longint frac, l2, v, res;
		frac = 0;
		if (w == 0)
			return cfg.loudness_floor;
		e = 63;
		while (!w[e])
			e--;
		m = (e >= 31) ? (w >> (e - 31)) : (w << (31 - e));
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac = frac | (64'sd1 << i);
			end
		end
		l2 = longint'(e) * 65536 + frac;
		v = (l2 - 42 * 65536) * longint'(DB_PER_OCTAVE_Q16) + longint'(OFFSET_Q32);
		res = (v + (64'sd1 << 23)) >>> 24;
		if (res > 32767) res = 32767;
		if (res < -32768) res = -32768;
		if (res < longint'(cfg.loudness_floor)) res = longint'(cfg.loudness_floor);
		return res[15:0];
	endfunction

	task automatic take_frame(input logic [47:0] d, input logic last);
		logic signed [31:0] wl, wr, xr;
		logic [31:0] sl, sr;
		int unsigned len, p, count;
		logic [63:0] msl, msr;
		xr = cfg.mono_mode ? 32'sd0 : to_q28(d[47:24]);
		wl = biquad_step(0, 1, biquad_step(0, 0, to_q28(d[23:0])));
		wr = biquad_step(1, 1, biquad_step(1, 0, xr));
		len = (cfg.window_length > WINDOW_DEPTH_DEF) ? WINDOW_DEPTH_DEF : cfg.window_length;
		if (len != 0) begin
			p = wpos % len;
			sl = square_q28(wl);
			sr = square_q28(wr);
			if (filled) begin
				power_sum[0] -= square_store[0][p];
				power_sum[1] -= square_store[1][p];
			end
			square_store[0][p] = sl;
			square_store[1][p] = sr;
			power_sum[0] += sl;
			power_sum[1] += sr;
			p++;
			if (p >= len) begin
				p = 0;
				filled = 1;
			end
			wpos = p;
		end
		if (!last)
			return;
		count = filled ? len : wpos;
		if (count == 0) begin
			loudness_due.push_back(cfg.loudness_floor);
		end else begin
			msl = power_sum[0] / count;
			msr = cfg.mono_mode ? msl : power_sum[1] / count;
			loudness_due.push_back(loudness_from_power(64'(cfg.channel_gain) * (msl + msr)));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				for (int k = 0; k < 8; k++)
					taps[c][k] = '0;
				power_sum[c] = '0;
			end
			wpos = 0;
			filled = 0;
			cfg.window_length = WINDOW_LENGTH_RST;
			cfg.channel_gain = CHANNEL_GAIN_RST;
			cfg.loudness_floor = LOUDNESS_FLOOR_RST;
			cfg.mono_mode = 1'b0;
			loudness_due.delete();
			fail_count = 0;
			mismatches = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (loudness_due.size() == 0) begin
					fail_count++;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected loudness result %0d", $signed(m_axis_tdata));
				end else if (loudness_due[0] !== m_axis_tdata) begin
					fail_count++;
					mismatches++;
					if (mismatches <= 10)
						$display("loudness mismatch: expected %0d, actual %0d",
							loudness_due[0], $signed(m_axis_tdata));
					void'(loudness_due.pop_front());
				end else begin
					void'(loudness_due.pop_front());
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				take_frame(s_axis_tdata, s_axis_tlast);
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[3:2]))
					REG_WINDOW_LENGTH: begin
						cfg.window_length = pwdata[15:0];
						wpos = 0;
						filled = 0;
						power_sum[0] = '0;
						power_sum[1] = '0;
					end
					REG_CHANNEL_GAIN: cfg.channel_gain = pwdata[15:0];
					REG_LOUDNESS_FLOOR: cfg.loudness_floor = pwdata[15:0];
					default: cfg.mono_mode = pwdata[0];
				endcase
			end
			pending = loudness_due.size();
		end
	end

endmodule

@@ verif/momentary_loudness_meter_tb.sv @@
module momentary_loudness_meter_tb;
	import mlm_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 600;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	bit          jitter = 1;
	int          stall_left = 0;
	int          quiet = 0;

	momentary_loudness_meter dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	momentary_loudness_meter_checker check (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [23:0] pick_sample();
		logic signed [23:0] s;
		case ($urandom_range(0, 3))
			0: s = $urandom;
			1: s = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			default: begin
				s = $urandom;
				s = s >>> $urandom_range(4, 20);
			end
		endcase
		return s;
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= 1;
			if (jitter && $urandom_range(0, 3) == 0)
				stall_left <= idle_gap();
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("momentary_loudness_meter verification failed");
			$finish;
		end
	end

	task automatic send_frame(input logic [23:0] l, input logic [23:0] r, input logic last);
		int g;
		g = jitter ? idle_gap() : 0;
		if (g > 0) begin
			s_axis_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {r, l};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic settle();
		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input reg_index_t idx, input logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		@(posedge clk);
	endtask

	task automatic load_config(input logic [15:0] wl, input logic [15:0] gain,
			input logic [15:0] floor_db, input logic mono);
		settle();
		apb_write(REG_WINDOW_LENGTH, {16'd0, wl});
		apb_write(REG_CHANNEL_GAIN, {16'd0, gain});
		apb_write(REG_LOUDNESS_FLOOR, {16'd0, floor_db});
		apb_write(REG_MONO_MODE, {31'd0, mono});
	endtask

	task automatic random_frames(input int n);
		for (int i = 0; i < n; i++)
			send_frame(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_frame(24'h000000, 24'h000000, 1);
		send_frame(24'h7FFFFF, 24'h7FFFFF, 1);
		send_frame(24'h800000, 24'h800000, 1);
		send_frame(24'h7FFFFF, 24'h800000, 0);
		send_frame(24'h800000, 24'h7FFFFF, 1);
		send_frame(24'h000001, 24'hFFFFFF, 1);
		send_frame(24'h555555, 24'hAAAAAA, 1);

		load_config(16'd0, 16'd16384, 16'h8000, 1'b0);
		send_frame(24'h7FFFFF, 24'h800000, 1);
		send_frame(24'h123456, 24'h654321, 1);

		load_config(16'd1, 16'd65535, 16'h0000, 1'b1);
		send_frame(24'h7FFFFF, 24'h7FFFFF, 1);
		send_frame(24'h001000, 24'h800000, 1);
		send_frame(24'h800000, 24'h000000, 1);

		load_config(16'd65535, 16'd0, 16'hBA00, 1'b0);
		send_frame(24'h7FFFFF, 24'h800000, 1);
		send_frame(24'h400000, 24'h400000, 1);

		load_config(16'd3, 16'd65535, 16'h8000, 1'b0);
		send_frame(24'h7FFFFF, 24'h7FFFFF, 0);
		send_frame(24'h800000, 24'h800000, 0);
		send_frame(24'h7FFFFF, 24'h800000, 1);
		send_frame(24'h000010, 24'h000020, 1);
		send_frame(24'h000000, 24'h000000, 1);

		for (int ph = 0; ph < 6; ph++) begin
			load_config((ph == 5) ? 16'd32768 : 16'($urandom_range(1, 48)),
				16'($urandom), 16'(-$urandom_range(0, 32768)), 1'($urandom_range(0, 1)));
			jitter = (ph != 2);
			random_frames(255);
		end
		jitter = 1;

		settle();
		if (fail_count == 0 && pending == 0)
			$display("momentary_loudness_meter verification clean");
		else
			$display("momentary_loudness_meter verification failed");
		$finish;
	end

endmodule
